### design/class_run_domain_builder_unit_defines.svh
// Assertion helpers shared by the files that check this block.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef CLASS_RUN_DOMAIN_BUILDER_UNIT_DEFINES_SVH
`define CLASS_RUN_DOMAIN_BUILDER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRDB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/crdb_pkg.sv
package crdb_pkg;

    // Fixed field widths.
    localparam int CHROM_W = 10;
    localparam int COORD_W = 32;

    // Reset value of the minimum run length register.
    localparam int MIN_COUNT_RESET = 20;

    // Sequencer states of the run builder.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_SEND
    } crdb_state_t;

    // Status returned by the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### design/class_run_domain_builder_unit.sv
// Channel  Dir  Request contents
// s_*      in   one site; tuser carries site_class, tlast carries segment_last
// m_*      out  one domain; tlast carries last_result
// cfg_*    in   min_count write data
//
// A site that closes no domain passes through CHECK, UPDATE and CHECK again before
// the next site is accepted. Each domain it emits passes through the serial divider,
// which works through the COUNT_BITS + SCORE_BITS bits of the run sum, then the
// output register, where it waits for as long as m_tready stays low.
// The input stays not ready until every domain of the site has been taken.
// rst_n clears the open run and sets min_count to 20; cfg writes are taken every cycle.
`include "class_run_domain_builder_unit_defines.svh"

module class_run_domain_builder_unit
    import crdb_pkg::*;
#(
    parameter int COUNT_BITS = 20,
    parameter int SCORE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // From the lowest bit: chrom_id, site_start, site_end, site_score, zero fill.
    input  logic [((2*COORD_W+CHROM_W+SCORE_BITS+7)/8)*8-1:0] s_tdata,
    // site_class.
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From the lowest bit: out_chrom, domain_start, domain_end, site_count,
    // mean_score, zero fill.
    output logic [((2*COORD_W+CHROM_W+COUNT_BITS+SCORE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [COUNT_BITS-1:0] cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int SUM_W      = COUNT_BITS + SCORE_BITS;
    localparam int START_LSB  = CHROM_W;
    localparam int END_LSB    = CHROM_W + COORD_W;
    localparam int SCORE_LSB  = CHROM_W + 2*COORD_W;
    localparam int M_TDATA_W  = ((2*COORD_W+CHROM_W+COUNT_BITS+SCORE_BITS+7)/8)*8;

    crdb_state_t state_reg, state_next;

    // Configuration.
    logic [COUNT_BITS-1:0] min_count_reg;

    // Latched input site.
    logic [CHROM_W-1:0]    in_chrom_reg;
    logic [COORD_W-1:0]    in_start_reg;
    logic [COORD_W-1:0]    in_end_reg;
    logic [SCORE_BITS-1:0] in_score_reg;
    logic                  in_class_reg;
    logic                  in_last_reg;

    // Open run.
    logic                  run_active_reg;
    logic                  run_class_reg;
    logic [CHROM_W-1:0]    run_chrom_reg;
    logic [COORD_W-1:0]    run_first_start_reg;
    logic [COORD_W-1:0]    run_last_end_reg;
    logic [COUNT_BITS-1:0] run_sites_reg;
    logic [SUM_W-1:0]      run_sum_reg;

    // Sequencer flags: phase 0 is the class change close, phase 1 the segment end.
    logic                  phase_reg;
    logic                  pend_reg;
    logic                  more_reg;

    // Output register.
    logic [CHROM_W-1:0]    out_chrom_reg;
    logic [COORD_W-1:0]    out_start_reg;
    logic [COORD_W-1:0]    out_end_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [SCORE_BITS-1:0] out_mean_reg;
    logic                  out_last_reg;

    logic                  in_acc;
    logic                  out_acc;
    logic                  close_cond;
    logic                  close_qual;
    logic                  div_go;
    logic [SUM_W:0]        sum_ext;
    logic [SCORE_BITS-1:0] mean_clamped;
    logic [SUM_W-1:0]      quotient;
    div_stat_t             div_stat;

    // Shared serial divider for the run means.
    crdb_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (run_sum_reg),
        .divisor  (run_sites_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Close decision for the current phase and the clamped mean.
    always_comb
    begin
        if (!phase_reg)
            close_cond = run_active_reg && (run_class_reg != in_class_reg);
        else
            close_cond = in_last_reg;
        close_qual = close_cond && run_active_reg && run_class_reg
                     && (run_sites_reg > min_count_reg);
        sum_ext = {1'b0, run_sum_reg} + (SUM_W+1)'(in_score_reg);
        if (quotient[SUM_W-1:SCORE_BITS] != '0)
            mean_clamped = '1;
        else
            mean_clamped = quotient[SCORE_BITS-1:0];
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        div_go     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!phase_reg)
                begin
                    div_go     = close_qual;
                    state_next = close_qual ? ST_DIV : ST_UPDATE;
                end
                else if (pend_reg)
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    div_go     = close_qual;
                    state_next = close_qual ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = phase_reg ? ST_SEND : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_CHECK;
            end
            ST_SEND:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    div_go     = more_reg;
                    state_next = more_reg ? ST_DIV : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_count_reg <= COUNT_BITS'(MIN_COUNT_RESET);
        else if (cfg_valid && cfg_ready)
            min_count_reg <= cfg_data;
    end

    // Sequencer flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            more_reg     <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg <= 1'b0;
                pend_reg  <= 1'b0;
            end
            if (state_reg == ST_UPDATE)
                phase_reg <= 1'b1;
            if (state_reg == ST_DIV && div_stat.done)
            begin
                if (!phase_reg)
                    pend_reg <= 1'b1;
                else
                    out_last_reg <= 1'b1;
            end
            if (state_reg == ST_CHECK && phase_reg && pend_reg)
            begin
                more_reg     <= close_qual;
                out_last_reg <= !close_qual;
            end
            if (out_acc)
            begin
                pend_reg <= 1'b0;
                more_reg <= 1'b0;
            end
        end
    end

    // Run state: close on request, then extend or open with the latched site.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg      <= 1'b0;
            run_class_reg       <= 1'b0;
            run_chrom_reg       <= '0;
            run_first_start_reg <= '0;
            run_last_end_reg    <= '0;
            run_sites_reg       <= '0;
            run_sum_reg         <= '0;
        end
        else if (state_reg == ST_CHECK && close_cond)
        begin
            run_active_reg <= 1'b0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            run_active_reg   <= 1'b1;
            run_last_end_reg <= in_end_reg;
            if (run_active_reg)
            begin
                if (run_sites_reg != '1)
                    run_sites_reg <= run_sites_reg + 1'b1;
                if (sum_ext[SUM_W])
                    run_sum_reg <= '1;
                else
                    run_sum_reg <= sum_ext[SUM_W-1:0];
            end
            else
            begin
                run_class_reg       <= in_class_reg;
                run_chrom_reg       <= in_chrom_reg;
                run_first_start_reg <= in_start_reg;
                run_sites_reg       <= COUNT_BITS'(1);
                run_sum_reg         <= SUM_W'(in_score_reg);
            end
        end
    end

    // Input latch and output payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_chrom_reg <= s_tdata[CHROM_W-1:0];
            in_start_reg <= s_tdata[START_LSB +: COORD_W];
            in_end_reg   <= s_tdata[END_LSB +: COORD_W];
            in_score_reg <= s_tdata[SCORE_LSB +: SCORE_BITS];
            in_class_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (div_go)
        begin
            out_chrom_reg <= run_chrom_reg;
            out_start_reg <= run_first_start_reg;
            out_end_reg   <= run_last_end_reg;
            out_count_reg <= run_sites_reg;
        end
        if (state_reg == ST_DIV && div_stat.done)
            out_mean_reg <= mean_clamped;
    end

    assign m_tdata = M_TDATA_W'({out_mean_reg, out_count_reg, out_end_reg,
                                 out_start_reg, out_chrom_reg});
    assign m_tlast = out_last_reg;

    // Checks on the sequencer.
    `CRDB_ASSERT_IMPLY(a_ready_not_busy, s_tready, !m_tvalid, "input ready while a domain waits")
    `CRDB_ASSERT_IMPLY(a_div_owned, div_stat.busy, state_reg == ST_DIV, "divider busy outside DIV")
    `CRDB_ASSERT_NEXT(a_last_frees, out_acc && m_tlast, s_tready, "not ready after last domain")
    `CRDB_ASSERT_IMPLY(a_run_count, run_active_reg, run_sites_reg != '0, "open run with no sites")

endmodule

### design/crdb_div.sv
// Restoring divider, one quotient bit per cycle.
module crdb_div
    import crdb_pkg::*;
#(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_stat_t             stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Shift in the next dividend bit and try one subtraction.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    // Control: count the steps and flag completion for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### sim/tb_class_run_domain_builder_unit.sv
`timescale 1ns / 1ps

module tb_class_run_domain_builder_unit;
    import crdb_pkg::*;

    localparam int COUNT_W = 20;
    localparam int SCORE_W = 16;
    localparam int SUM_W   = COUNT_W + SCORE_W;
    localparam int S_W     = ((2*COORD_W + CHROM_W + SCORE_W + 7) / 8) * 8;
    localparam int M_W     = ((2*COORD_W + CHROM_W + COUNT_W + SCORE_W + 7) / 8) * 8;

    // Bit offsets inside the packed data words.
    localparam int START_LSB = CHROM_W;
    localparam int END_LSB   = START_LSB + COORD_W;
    localparam int TAIL_LSB  = END_LSB + COORD_W;
    localparam int MEAN_LSB  = TAIL_LSB + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] site_start;
        logic [COORD_W-1:0] site_end;
        logic [SCORE_W-1:0] score;
        logic               fg;
        logic               seg_last;
    } site_t;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] dom_start;
        logic [COORD_W-1:0] dom_end;
        logic [COUNT_W-1:0] sites;
        logic [SCORE_W-1:0] mean;
        logic               is_last;
    } domain_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic [S_W-1:0]     s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               s_tlast = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [M_W-1:0]     m_tdata;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;

    class_run_domain_builder_unit #(
        .COUNT_BITS(COUNT_W),
        .SCORE_BITS(SCORE_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_data(cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    // Sites waiting to be sent, and domains waiting to come out.
    site_t   site_backlog[$];
    domain_t expected_domains[$];
    site_t   site_on_bus;
    bit      site_taken = 1'b0;

    int unsigned error_count = 0;
    int unsigned sites_accepted = 0;
    int unsigned domains_checked = 0;
    int unsigned settings_used = 0;

    // Shadow of the run builder state.
    logic [COUNT_W-1:0] min_sites = COUNT_W'(MIN_COUNT_RESET);
    logic               run_open = 1'b0;
    logic               run_fg = 1'b0;
    logic [CHROM_W-1:0] run_chrom = '0;
    logic [COORD_W-1:0] run_first_start = '0;
    logic [COORD_W-1:0] run_last_end = '0;
    logic [COUNT_W-1:0] run_sites = '0;
    logic [SUM_W-1:0]   run_score_sum = '0;

    // Clock and reset.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d sites queued and %0d domains outstanding.",
                 site_backlog.size(), expected_domains.size());
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Closes the open run and records a domain if it is foreground and long enough.
    task automatic close_run(ref domain_t closed[$]);
        domain_t d;
        logic [SUM_W-1:0] quotient;
        if (run_open && run_fg && run_sites > min_sites)
        begin
            quotient = (run_sites == '0) ? '0 : run_score_sum / run_sites;
            if (quotient > SUM_W'(SCORE_MAX))
                quotient = SUM_W'(SCORE_MAX);
            d.chrom     = run_chrom;
            d.dom_start = run_first_start;
            d.dom_end   = run_last_end;
            d.sites     = run_sites;
            d.mean      = quotient[SCORE_W-1:0];
            d.is_last   = 1'b0;
            closed = {closed, d};
        end
        run_open = 1'b0;
    endtask

    // Adds one accepted site to the run and queues the domains it closes.
    task automatic fold_site_into_run(input site_t s);
        domain_t closed[$];
        if (run_open && run_fg != s.fg)
            close_run(closed);
        if (run_open)
        begin
            if (run_sites != COUNT_MAX)
                run_sites++;
            if (SUM_MAX - run_score_sum < SUM_W'(s.score))
                run_score_sum = SUM_MAX;
            else
                run_score_sum += SUM_W'(s.score);
            run_last_end = s.site_end;
        end
        else
        begin
            run_open        = 1'b1;
            run_fg          = s.fg;
            run_chrom       = s.chrom;
            run_first_start = s.site_start;
            run_last_end    = s.site_end;
            run_sites       = COUNT_W'(1);
            run_score_sum   = SUM_W'(s.score);
        end
        if (s.seg_last)
            close_run(closed);
        foreach (closed[i])
        begin
            closed[i].is_last = (i == closed.size() - 1);
            expected_domains = {expected_domains, closed[i]};
        end
    endtask

    // Sender: bursts of requests with random gaps, some stretches with none.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge clk)
    begin : site_driver
        site_t nxt;
        if (rst_n && !(s_tvalid && !site_taken))
        begin
            site_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (site_backlog.size() > 0)
            begin
                nxt = site_backlog.pop_front();
                site_on_bus = nxt;
                s_tdata <= S_W'({nxt.score, nxt.site_end, nxt.site_start, nxt.chrom});
                s_tuser <= nxt.fg;
                s_tlast <= nxt.seg_last;
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches among steady, random and periodic stall styles.
    int unsigned stall_span = 0;
    int unsigned stall_style = 0;

    always @(negedge clk)
    begin : domain_sink
        if (stall_span == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 150);
        end
        stall_span--;
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ((stall_span % 16) >= 10);
        endcase
    end

    // Checks each domain against the oldest expectation, then folds in accepted sites.
    always @(posedge clk)
    begin : scoreboard
        domain_t got;
        domain_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.chrom     = m_tdata[CHROM_W-1:0];
                got.dom_start = m_tdata[START_LSB +: COORD_W];
                got.dom_end   = m_tdata[END_LSB +: COORD_W];
                got.sites     = m_tdata[TAIL_LSB +: COUNT_W];
                got.mean      = m_tdata[MEAN_LSB +: SCORE_W];
                got.is_last   = m_tlast;
                if (expected_domains.size() == 0)
                begin
                    report_mismatch("unexpected domain, start", got.dom_start, '0);
                end
                else
                begin
                    want = expected_domains.pop_front();
                    domains_checked++;
                    check_field("out_chrom", got.chrom, want.chrom);
                    check_field("domain_start", got.dom_start, want.dom_start);
                    check_field("domain_end", got.dom_end, want.dom_end);
                    check_field("site_count", got.sites, want.sites);
                    check_field("mean_score", got.mean, want.mean);
                    check_field("last_result", got.is_last, want.is_last);
                end
            end
            if (s_tvalid && s_tready)
            begin
                fold_site_into_run(site_on_bus);
                sites_accepted++;
                site_taken = 1'b1;
            end
        end
    end

    // Waits until every site is taken, every domain has come out and the block is ready.
    task automatic wait_idle();
        while (site_backlog.size() != 0 || s_tvalid || expected_domains.size() != 0)
            @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_min_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        min_sites = value;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic site_t make_site(input logic [CHROM_W-1:0] chrom,
                                        input logic [COORD_W-1:0] first,
                                        input logic [COORD_W-1:0] latest,
                                        input logic [SCORE_W-1:0] score,
                                        input logic fg, input logic seg_last);
        site_t s;
        s.chrom      = chrom;
        s.site_start = first;
        s.site_end   = latest;
        s.score      = score;
        s.fg         = fg;
        s.seg_last   = seg_last;
        return s;
    endfunction

    // Appends one site to the send backlog.
    task automatic append_site(input site_t s);
        site_backlog = {site_backlog, s};
    endtask

    // Queues one segment of alternating runs; a noisy segment has random classes
    // and stray segment ends.
    task automatic queue_segment(input int unsigned runs, input int unsigned min_len,
                                 input int unsigned max_len, input bit noisy,
                                 ref int unsigned queued);
        site_t s;
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] coord;
        logic fg;
        int unsigned len;
        chrom = CHROM_W'($urandom_range(0, 1023));
        coord = $urandom;
        fg = 1'($urandom_range(0, 1));
        for (int r = 0; r < runs; r++)
        begin
            len = $urandom_range(min_len, max_len);
            for (int k = 0; k < len; k++)
            begin
                s.chrom = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023)) : chrom;
                s.site_start = coord;
                s.site_end = coord + $urandom_range(1, 2000);
                coord = s.site_end + $urandom_range(0, 500);
                // Occasionally coordinates out of order.
                if ($urandom_range(0, 19) == 0)
                begin
                    s.site_start = $urandom;
                    s.site_end = $urandom;
                end
                case ($urandom_range(0, 9))
                    0: s.score = '0;
                    1: s.score = SCORE_MAX;
                    default: s.score = SCORE_W'($urandom_range(0, 65535));
                endcase
                s.fg = noisy ? 1'($urandom_range(0, 1)) : fg;
                s.seg_last = noisy && ($urandom_range(0, 7) == 0);
                append_site(s);
                queued++;
            end
            // Mostly alternate; keeping the class merges two runs into one.
            if ($urandom_range(0, 5) != 0)
                fg = !fg;
        end
        site_backlog[site_backlog.size() - 1].seg_last = 1'b1;
    endtask

    // Random traffic shaped around the current minimum run length.
    task automatic random_phase(input int unsigned target, ref int unsigned queued);
        int unsigned lo;
        int unsigned hi;
        int unsigned done_here;
        done_here = 0;
        if (min_sites <= 30)
        begin
            lo = (min_sites > 2) ? min_sites - 2 : 1;
            hi = min_sites + 3;
        end
        else
        begin
            lo = 1;
            hi = 6;
        end
        while (done_here < target)
            queue_segment($urandom_range(1, 6), lo, hi, $urandom_range(0, 4) == 0, done_here);
        queued += done_here;
    endtask

    // Stimulus sequence.
    initial
    begin : stimulus
        int unsigned queued;
        queued = 0;
        @(posedge rst_n);

        // Reset value of the minimum run length.
        settings_used = 1;
        random_phase(120, queued);

        // Directed sites with every foreground run emitted.
        write_min_count('0);
        append_site(make_site('1, '1, '1, '1, 1'b1, 1'b1));
        append_site(make_site('0, '0, '0, '0, 1'b1, 1'b1));
        append_site(make_site(10'd3, 32'd10, 32'd20, 16'd500, 1'b0, 1'b1));
        // Chromosome change inside a run, coordinates going backward, closed by class.
        append_site(make_site(10'd5, 32'd100, 32'd200, 16'd1, 1'b1, 1'b0));
        append_site(make_site(10'd9, 32'd50, 32'd40, 16'd2, 1'b1, 1'b0));
        append_site(make_site(10'd9, 32'd300, 32'd400, 16'd7, 1'b0, 1'b1));
        // Background run closed by a foreground run, which ends the segment.
        append_site(make_site(10'd1, 32'd1, 32'd2, 16'd9, 1'b0, 1'b0));
        append_site(make_site(10'd2, 32'd3, 32'd4, 16'd100, 1'b1, 1'b0));
        append_site(make_site(10'd2, 32'd5, 32'd6, 16'd101, 1'b1, 1'b1));
        // Full scale scores average to full scale.
        repeat (2) append_site(make_site(10'd7, 32'hFFFF_0000, 32'hFFFF_1000,
                                         '1, 1'b1, 1'b0));
        append_site(make_site(10'd7, 32'hFFFF_2000, '1, '1, 1'b1, 1'b1));
        queued += 12;

        // A run of exactly the minimum is dropped, one more is emitted.
        write_min_count(20'd2);
        repeat (2) append_site(make_site(10'd4, $urandom, $urandom,
                                         SCORE_W'($urandom), 1'b1, 1'b0));
        site_backlog[site_backlog.size() - 1].seg_last = 1'b1;
        repeat (3) append_site(make_site(10'd4, $urandom, $urandom,
                                         SCORE_W'($urandom), 1'b1, 1'b0));
        site_backlog[site_backlog.size() - 1].seg_last = 1'b1;
        queued += 5;

        // Random phases across several settings, extremes included.
        write_min_count(20'd1);
        random_phase(170, queued);
        write_min_count('0);
        random_phase(170, queued);
        write_min_count(20'd3);
        random_phase(170, queued);
        write_min_count('1);
        random_phase(120, queued);
        write_min_count(20'd2);
        random_phase(170, queued);
        write_min_count(COUNT_W'($urandom_range(0, 6)));
        random_phase(170, queued);
        write_min_count(20'd5);
        random_phase(150, queued);
        write_min_count(COUNT_W'($urandom_range(0, 20'hFFFFF)));
        random_phase(60, queued);
        write_min_count(COUNT_W'(MIN_COUNT_RESET));
        random_phase(100, queued);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Run covered %0d sites (%0d queued) under %0d minimum run settings.",
                 sites_accepted, queued, settings_used);
        $display("%0d domains were compared, %0d mismatches seen.",
                 domains_checked, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
